// File: sv/htab_pkg.sv
// shared types and constants of the hash table engine
package htab_pkg;

  // table geometry, BUCKETS is a power of two
  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W = KEY_W + VAL_W;
  localparam int ROW_W  = WAYS * SLOT_W;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // one slot of a bucket row
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  // outcome of one operation on a bucket
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value_out;
    status_e          status;
    logic             wr_en;
    row_t             wr_row;
    logic             valid_set;
    logic             valid_clr;
    logic [WAY_W-1:0] way;
  } bkt_res_t;

endpackage

// File: sv/htab_ram.sv
// generic single-port-write, single-port-read ram with registered read
module htab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/htab_bucket.sv
// key match, free slot search and row update for one bucket
module htab_bucket import htab_pkg::*; (
  input  logic [1:0]       op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  input  row_t             row_i,
  input  logic [WAYS-1:0]  valid_i,
  output bkt_res_t         res_o
);

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             free;
  logic [WAY_W-1:0] free_way;

  // lowest matching way and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (row_i[w].key == key_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // operation decode and row modify
  always_comb begin
    res_o           = '0;
    res_o.found     = hit;
    res_o.status    = ST_MISS;
    res_o.wr_row    = row_i;
    res_o.way       = hit_way;
    case (op_e'(op_i))
      OP_PUT: begin
        if (hit) begin
          res_o.wr_row[hit_way].value = value_i;
          res_o.wr_en                 = 1'b1;
          res_o.status                = ST_UPDATED;
        end else if (free) begin
          res_o.wr_row[free_way].key   = key_i;
          res_o.wr_row[free_way].value = value_i;
          res_o.wr_en                  = 1'b1;
          res_o.valid_set              = 1'b1;
          res_o.way                    = free_way;
          res_o.status                 = ST_INSERTED;
        end else begin
          res_o.status = ST_FULL;
        end
      end
      OP_GET: begin
        if (hit) begin
          res_o.value_out = row_i[hit_way].value;
          res_o.status    = ST_HIT;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          res_o.valid_clr = 1'b1;
          res_o.status    = ST_REMOVED;
        end
      end
      default: begin
        res_o.found = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/hash_table_engine.sv
// top level of the hash table engine: control, valid bits and bucket ram
//
//  channel   signals                         transfer when
//  command   start, busy, op_i/key_i/value_i start high and busy low at a clock edge
//  result    done_o, found_o/value_out_o/    done_o high, one cycle per result
//            status_o
//
// an operation runs as follows: the accept cycle reads the bucket row from the
// ram, the next cycle matches, writes the row back and registers the result.
// done_o rises the cycle after that; a new command can be accepted in that same
// cycle; busy holds off a new command until the last one has executed.
// reset clears all slot valid bits at once; no clearing pass is needed.
// results cannot be stalled by the receiver.
module hash_table_engine import htab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [VAL_W-1:0] value_i,
  output logic             done_o,
  output logic             found_o,
  output logic [VAL_W-1:0] value_out_o,
  output logic [2:0]       status_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                         state_q, state_d;
  logic [BUCKETS-1:0][WAYS-1:0]   valid_q;
  logic                           done_q;
  logic [1:0]                     op_q;
  logic [KEY_W-1:0]               key_q;
  logic [VAL_W-1:0]               value_q;
  logic [BKT_W-1:0]               bucket_q, bucket_d;
  logic                           found_q;
  logic [VAL_W-1:0]               value_out_q;
  logic [2:0]                     status_q;
  logic                           accept;
  logic                           exec;
  logic [KEY_W-1:0]               mag;
  logic [ROW_W-1:0]               rd_data;
  row_t                           row;
  bkt_res_t                       res;

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;
  assign exec   = (state_q == S_EXEC);

  // bucket index from key magnitude
  assign mag      = key_i[KEY_W-1] ? (KEY_W'(0) - key_i) : key_i;
  assign bucket_d = BKT_W'(mag % BUCKETS);

  // bucket row storage
  htab_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (exec && res.wr_en),
    .waddr_i(bucket_q),
    .wdata_i(ROW_W'(res.wr_row)),
    .re_i   (accept),
    .raddr_i(bucket_d),
    .rdata_o(rd_data)
  );

  assign row = row_t'(rd_data);

  // match and update logic
  htab_bucket u_bucket (
    .op_i   (op_q),
    .key_i  (key_q),
    .value_i(value_q),
    .row_i  (row),
    .valid_i(valid_q[bucket_q]),
    .res_o  (res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec && res.valid_set) begin
        valid_q[bucket_q][res.way] <= 1'b1;
      end else if (exec && res.valid_clr) begin
        valid_q[bucket_q][res.way] <= 1'b0;
      end
    end
  end

  // command capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      key_q    <= key_i;
      value_q  <= value_i;
      bucket_q <= bucket_d;
    end
    if (exec) begin
      found_q     <= res.found;
      value_out_q <= res.value_out;
      status_q    <= res.status;
    end
  end

  assign done_o      = done_q;
  assign found_o     = found_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;

endmodule
